// ===== rtl/assert_macros.svh =====
// Assertion macros used by the scheduler port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion, checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== rtl/scd_pkg.sv =====
// Types, codes and sizes shared by the scheduler files.
package scd_pkg;

   localparam int NUM_SLOTS = 64;
   localparam int POS_W     = $clog2(NUM_SLOTS);
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
   localparam int SLOT_W    = 6;
   localparam int SLICE_W   = 8;

   localparam logic [SLICE_W-1:0] INIT_SLICE = 8'd10;

   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_SUBMIT = 2'd1;
   localparam logic [1:0] OP_SWITCH = 2'd2;
   localparam logic [1:0] OP_SLEEP  = 2'd3;

   localparam logic [1:0] ST_FREE  = 2'd0;
   localparam logic [1:0] ST_ALLOC = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_NOFREE = 2'd1;
   localparam logic [1:0] STAT_NOTRUN = 2'd2;
   localparam logic [1:0] STAT_EMPTY  = 2'd3;

   typedef struct packed {
      logic [1:0]         operation;
      logic [SLOT_W-1:0]  slot;
      logic [SLICE_W-1:0] slice;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  task_slot;
      logic [SLICE_W-1:0] time_slice;
      logic               do_switch;
      logic [1:0]         status;
   } rsp_type;

   // one slot table entry plus one run list entry
   typedef struct packed {
      logic [1:0]         state;
      logic [SLICE_W-1:0] slice;
      logic [SLOT_W-1:0]  task_id;
      logic [SLICE_W-1:0] task_slice;
      logic               drop;
   } cell_type;

   typedef struct packed {
      logic shift;
      logic compact;
      logic load;
   } cell_ctl_type;

endpackage

// ===== rtl/scd_cell.sv =====
// One scheduler cell: a slot table entry and a run list entry in a rotating chain.
module scd_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  scd_pkg::cell_ctl_type ctl,
   input  scd_pkg::cell_type    init_val,
   input  scd_pkg::cell_type    nbr,
   input  scd_pkg::cell_type    load_val,
   output scd_pkg::cell_type    q
);
   import scd_pkg::*;

   cell_type data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.shift) begin
         data_in = nbr;
      end else if (ctl.compact) begin
         if (data_ff.drop) begin
            data_in.task_id    = nbr.task_id;
            data_in.task_slice = nbr.task_slice;
         end
         data_in.drop = 1'b0;
      end else if (ctl.load) begin
         data_in.task_id    = load_val.task_id;
         data_in.task_slice = load_val.task_slice;
         data_in.drop       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= init_val;
      end else begin
         data_ff <= data_in;
      end
   end

   assign q = data_ff;

endmodule

// ===== rtl/round_robin_task_scheduler.sv =====
// Round robin task scheduler: sequencer, head logic and the chain of cells.
//
// Usage: one request item on req_* (operation, slot, slice) gives exactly one
// response item on rsp_* (task_slot, time_slice, do_switch, status). Both
// channels use valid/ready; an item moves when valid and ready are high.
// Every slot's table entry and every run list entry lives in one cell of a
// ring of NUM_SLOTS cells. Each request rotates the whole ring once, one cell
// per cycle past the head logic, which reads and updates the entry there.
// The response is registered: it is written to the output register once the
// rotation is through. One request is worked on at a time, so a new request is
// taken only once the last one has put its response into the output register.
// req_ready is high whenever no request is in work, even while a response
// still waits in the output register. If rsp_ready stays low, a finished
// request holds in its last step until the output register frees up.
// Reset is synchronous: slot 0 is running with slice 10, all other slots are
// free, the run list holds slot 0 only, and both channels come up empty.
module round_robin_task_scheduler (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  scd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output scd_pkg::rsp_type rsp_data
);
   import scd_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [POS_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               found_ff, found_in;
   logic               early_ff, early_in;
   logic               hit_cur_ff, hit_cur_in;
   logic               append_ff, append_in;
   logic               rsp_valid_ff, rsp_valid_in;
   req_type            cmd_ff, cmd_in;
   rsp_type            rsp_ff, rsp_in;
   logic [SLOT_W-1:0]  pick_slot_ff, pick_slot_in;
   logic [SLICE_W-1:0] pick_slice_ff, pick_slice_in;
   logic [SLOT_W-1:0]  cur_task_ff, cur_task_in;
   logic [SLICE_W-1:0] cur_slice_ff, cur_slice_in;
   logic [SLOT_W-1:0]  nxt_task_ff, nxt_task_in;
   logic [SLICE_W-1:0] nxt_slice_ff, nxt_slice_in;

   cell_type           q [NUM_SLOTS];
   cell_type           head;
   cell_type           tail;
   cell_type           load_val;
   logic               shift_en;
   logic               compact_en;
   logic               load_en;

   logic [CNT_W-1:0]   pos_inc;
   logic [POS_W-1:0]   nxt_pos;
   logic [CNT_W-1:0]   new_count;
   logic               slot_ok;
   logic               in_list;
   logic               at_slot;
   logic               match;
   logic [SLICE_W-1:0] new_slice;

   assign head      = q[0];
   assign pos_inc   = CNT_W'(pos_ff) + CNT_W'(1);
   assign nxt_pos   = (pos_inc == count_ff) ? '0 : POS_W'(pos_inc);
   assign new_count = count_ff - CNT_W'(1);
   assign slot_ok   = CNT_W'(cmd_ff.slot) < CNT_W'(NUM_SLOTS);
   assign in_list   = CNT_W'(step_ff) < count_ff;
   assign at_slot   = step_ff == POS_W'(cmd_ff.slot);
   assign match     = in_list && (head.task_id == cmd_ff.slot);
   assign new_slice = (cmd_ff.slice != '0) ? cmd_ff.slice : head.slice;

   always_comb begin
      load_val            = '0;
      load_val.task_id    = cmd_ff.slot;
      load_val.task_slice = pick_slice_ff;
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      found_in      = found_ff;
      early_in      = early_ff;
      hit_cur_in    = hit_cur_ff;
      append_in     = append_ff;
      cmd_in        = cmd_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      pick_slot_in  = pick_slot_ff;
      pick_slice_in = pick_slice_ff;
      cur_task_in   = cur_task_ff;
      cur_slice_in  = cur_slice_ff;
      nxt_task_in   = nxt_task_ff;
      nxt_slice_in  = nxt_slice_ff;
      tail          = head;
      shift_en      = 1'b0;
      compact_en    = 1'b0;
      load_en       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_data;
               step_in    = '0;
               found_in   = 1'b0;
               early_in   = 1'b0;
               hit_cur_in = 1'b0;
               append_in  = 1'b0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            shift_en = 1'b1;
            step_in  = step_ff + POS_W'(1);
            if (step_ff == POS_W'(NUM_SLOTS - 1)) begin
               state_in = S_DONE;
            end
            if (step_ff == pos_ff) begin
               cur_task_in  = head.task_id;
               cur_slice_in = head.task_slice;
               early_in     = found_ff;
               hit_cur_in   = match;
            end
            if (step_ff == nxt_pos) begin
               nxt_task_in  = head.task_id;
               nxt_slice_in = head.task_slice;
            end
            unique case (cmd_ff.operation)
               OP_ALLOC: begin
                  if (!found_ff && head.state == ST_FREE) begin
                     found_in      = 1'b1;
                     pick_slot_in  = SLOT_W'(step_ff);
                     pick_slice_in = head.slice;
                     tail.state    = ST_ALLOC;
                  end
               end
               OP_SUBMIT: begin
                  if (slot_ok) begin
                     if (at_slot) begin
                        tail.slice    = new_slice;
                        tail.state    = ST_RUN;
                        pick_slice_in = new_slice;
                        append_in     = head.state != ST_RUN;
                     end
                     if (match && cmd_ff.slice != '0) begin
                        tail.task_slice = cmd_ff.slice;
                     end
                  end
               end
               OP_SWITCH: begin
               end
               OP_SLEEP: begin
                  if (slot_ok) begin
                     if (at_slot && head.state == ST_RUN) begin
                        tail.state = ST_ALLOC;
                     end
                     found_in  = found_ff | match;
                     tail.drop = found_ff | match;
                  end
               end
            endcase
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               state_in     = S_IDLE;
               unique case (cmd_ff.operation)
                  OP_ALLOC: begin
                     if (found_ff) begin
                        rsp_in.task_slot  = pick_slot_ff;
                        rsp_in.time_slice = pick_slice_ff;
                        rsp_in.status     = STAT_OK;
                     end else begin
                        rsp_in.status = STAT_NOFREE;
                     end
                  end
                  OP_SUBMIT: begin
                     if (!slot_ok) begin
                        rsp_in.status = STAT_NOTRUN;
                     end else begin
                        rsp_in.task_slot  = cmd_ff.slot;
                        rsp_in.time_slice = pick_slice_ff;
                        rsp_in.status     = STAT_OK;
                        if (append_ff && count_ff < CNT_W'(NUM_SLOTS)) begin
                           load_en  = 1'b1;
                           count_in = count_ff + CNT_W'(1);
                        end
                     end
                  end
                  OP_SWITCH: begin
                     if (count_ff == '0) begin
                        rsp_in.status = STAT_EMPTY;
                     end else begin
                        pos_in            = nxt_pos;
                        rsp_in.task_slot  = nxt_task_ff;
                        rsp_in.time_slice = nxt_slice_ff;
                        rsp_in.do_switch  = count_ff >= CNT_W'(2);
                        rsp_in.status     = STAT_OK;
                     end
                  end
                  OP_SLEEP: begin
                     if (!slot_ok || !found_ff) begin
                        rsp_in.status = STAT_NOTRUN;
                     end else begin
                        compact_en = 1'b1;
                        count_in   = new_count;
                        if (new_count == '0) begin
                           pos_in        = '0;
                           rsp_in.status = STAT_EMPTY;
                        end else if (hit_cur_ff) begin
                           pos_in            = (CNT_W'(pos_ff) >= new_count) ? '0 : pos_ff;
                           rsp_in.task_slot  = nxt_task_ff;
                           rsp_in.time_slice = nxt_slice_ff;
                           rsp_in.do_switch  = 1'b1;
                           rsp_in.status     = STAT_OK;
                        end else begin
                           if (early_ff) begin
                              pos_in = pos_ff - POS_W'(1);
                           end
                           rsp_in.task_slot  = cur_task_ff;
                           rsp_in.time_slice = cur_slice_ff;
                           rsp_in.status     = STAT_OK;
                        end
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         count_ff     <= CNT_W'(1);
         pos_ff       <= '0;
         found_ff     <= 1'b0;
         early_ff     <= 1'b0;
         hit_cur_ff   <= 1'b0;
         append_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         found_ff     <= found_in;
         early_ff     <= early_in;
         hit_cur_ff   <= hit_cur_in;
         append_ff    <= append_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      rsp_ff        <= rsp_in;
      pick_slot_ff  <= pick_slot_in;
      pick_slice_ff <= pick_slice_in;
      cur_task_ff   <= cur_task_in;
      cur_slice_ff  <= cur_slice_in;
      nxt_task_ff   <= nxt_task_in;
      nxt_slice_ff  <= nxt_slice_in;
   end

   for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
      cell_type     init_val;
      cell_type     nbr;
      cell_ctl_type ctl;

      always_comb begin
         init_val = '0;
         if (k == 0) begin
            init_val.state      = ST_RUN;
            init_val.slice      = INIT_SLICE;
            init_val.task_slice = INIT_SLICE;
         end
      end

      if (k == NUM_SLOTS - 1) begin : g_last
         assign nbr = tail;
      end else begin : g_mid
         assign nbr = q[k + 1];
      end

      assign ctl.shift   = shift_en;
      assign ctl.compact = compact_en;
      assign ctl.load    = load_en && (count_ff == CNT_W'(k));

      scd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .init_val (init_val),
         .nbr      (nbr),
         .load_val (load_val),
         .q        (q[k])
      );
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/scd_checker.sv =====
// Port checker for the scheduler, bound to the top level.
`include "assert_macros.svh"

module scd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input scd_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input scd_pkg::rsp_type rsp_data
);
   import scd_pkg::*;

   `ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))

   `ASSERT_RST(a_one_in_work, clock, reset, req_valid && req_ready |=> !req_ready)

   `ASSERT_RST(a_fail_zero, clock, reset, rsp_valid && rsp_data.status != STAT_OK |-> rsp_data.task_slot == '0 && rsp_data.time_slice == '0 && !rsp_data.do_switch)

   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && req_ready)

endmodule

bind round_robin_task_scheduler scd_checker u_scd_checker (.*);

// ===== dv/tb_round_robin_task_scheduler.sv =====
// Testbench for the round robin task scheduler: directed, random and full-list tests.
module tb_round_robin_task_scheduler;
   timeunit 1ns;
   timeprecision 1ps;

   import scd_pkg::*;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   round_robin_task_scheduler u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // scheduler state as the testbench sees it
   logic [1:0]         tbl_state [NUM_SLOTS];
   logic [SLICE_W-1:0] tbl_slice [NUM_SLOTS];
   logic [SLOT_W-1:0]  run_q     [NUM_SLOTS];
   int                 run_len;
   int                 cur_pos;

   rsp_type answer_q [$];
   rsp_type last_answer;
   bit      idle_on    = 1'b1;
   int      mismatches = 0;

   initial forever #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 100)
         $display("%0t ns: %s", $realtime, msg);
   endtask

   function automatic rsp_type current_answer(logic sw);
      rsp_type a;
      a = '0;
      if (run_len == 0 || cur_pos >= run_len) begin
         a.status = STAT_EMPTY;
      end else begin
         a.task_slot  = run_q[cur_pos];
         a.time_slice = tbl_slice[run_q[cur_pos]];
         a.do_switch  = sw;
         a.status     = STAT_OK;
      end
      return a;
   endfunction

   function automatic rsp_type schedule_request(req_type r);
      rsp_type a;
      int      i;
      int      hit;
      logic    was_cur;
      a = '0;
      case (r.operation)
         OP_ALLOC: begin
            a.status = STAT_NOFREE;
            for (i = 0; i < NUM_SLOTS && a.status == STAT_NOFREE; i++) begin
               if (tbl_state[i] == ST_FREE) begin
                  tbl_state[i] = ST_ALLOC;
                  a.task_slot  = SLOT_W'(i);
                  a.time_slice = tbl_slice[i];
                  a.status     = STAT_OK;
               end
            end
         end
         OP_SUBMIT: begin
            if (r.slice != '0)
               tbl_slice[r.slot] = r.slice;
            if (tbl_state[r.slot] != ST_RUN && run_len < NUM_SLOTS) begin
               tbl_state[r.slot] = ST_RUN;
               run_q[run_len]    = r.slot;
               run_len++;
            end
            a.task_slot  = r.slot;
            a.time_slice = tbl_slice[r.slot];
            a.status     = STAT_OK;
         end
         OP_SWITCH: begin
            if (run_len == 0) begin
               a.status = STAT_EMPTY;
            end else begin
               cur_pos = (cur_pos + 1) % run_len;
               a = current_answer(run_len >= 2);
            end
         end
         default: begin
            if (tbl_state[r.slot] != ST_RUN) begin
               a.status = STAT_NOTRUN;
            end else begin
               was_cur = cur_pos < run_len && run_q[cur_pos] == r.slot;
               hit = run_len;
               for (i = 0; i < run_len; i++)
                  if (run_q[i] == r.slot && hit == run_len)
                     hit = i;
               if (hit < run_len) begin
                  run_len--;
                  if (hit < cur_pos)
                     cur_pos--;
                  for (i = hit; i < run_len; i++)
                     run_q[i] = run_q[i + 1];
               end
               tbl_state[r.slot] = ST_ALLOC;
               if (run_len == 0) begin
                  cur_pos  = 0;
                  a.status = STAT_EMPTY;
               end else begin
                  if (cur_pos >= run_len)
                     cur_pos = 0;
                  a = current_answer(was_cur);
               end
            end
         end
      endcase
      return a;
   endfunction

   function automatic int running_slot();
      if (run_len > 0)
         return run_q[$urandom_range(0, run_len - 1)];
      return $urandom_range(0, NUM_SLOTS - 1);
   endfunction

   task automatic send_request(logic [1:0] op, int slot, int slice);
      req_type r;
      int      gap;
      r.operation = op;
      r.slot      = SLOT_W'(slot);
      r.slice     = SLICE_W'(slice);
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      last_answer = schedule_request(r);
      answer_q.push_back(last_answer);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (answer_q.size() != 0);
   endtask

   initial begin
      rsp_type want;
      int      stall;
      while (reset) @(posedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 9) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (answer_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item %p", rsp_data));
         end else begin
            want = answer_q.pop_front();
            if (rsp_data.task_slot !== want.task_slot)
               report_mismatch($sformatf("task_slot got %0d, expected %0d",
                                         rsp_data.task_slot, want.task_slot));
            if (rsp_data.time_slice !== want.time_slice)
               report_mismatch($sformatf("time_slice got %0d, expected %0d",
                                         rsp_data.time_slice, want.time_slice));
            if (rsp_data.do_switch !== want.do_switch)
               report_mismatch($sformatf("do_switch got %0d, expected %0d",
                                         rsp_data.do_switch, want.do_switch));
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status got %0d, expected %0d",
                                         rsp_data.status, want.status));
         end
      end
   end

   task automatic test_directed();
      send_request(OP_SWITCH, 0, 0);
      send_request(OP_ALLOC, 63, 255);
      send_request(OP_ALLOC, 0, 0);
      send_request(OP_SUBMIT, 1, 255);
      send_request(OP_SUBMIT, 1, 0);
      send_request(OP_SUBMIT, 5, 1);
      send_request(OP_SWITCH, 0, 0);
      send_request(OP_SWITCH, 0, 0);
      send_request(OP_SWITCH, 0, 0);
      send_request(OP_SLEEP, 2, 0);
      send_request(OP_SLEEP, 63, 0);
      send_request(OP_SLEEP, 5, 0);
      send_request(OP_SWITCH, 0, 0);
      send_request(OP_SLEEP, 1, 0);
      send_request(OP_SLEEP, 0, 0);
      send_request(OP_SWITCH, 0, 0);
      send_request(OP_ALLOC, 0, 0);
      send_request(OP_SUBMIT, 63, 128);
      send_request(OP_SLEEP, 63, 255);
      send_request(OP_SUBMIT, 2, 0);
      send_request(OP_SUBMIT, 0, 170);
      send_request(OP_SUBMIT, 1, 85);
      send_request(OP_SWITCH, 0, 0);
      send_request(OP_SLEEP, 0, 0);
      send_request(OP_SLEEP, 2, 0);
   endtask

   task automatic test_random();
      int  burst;
      int  pick;
      int  slot;
      int  slice;
      bit  grow;
      for (burst = 0; burst < 10; burst++) begin
         grow    = burst % 2 == 0;
         idle_on = burst % 3 != 2;
         if (burst == 5)
            wait_drained();
         repeat (30) begin
            pick  = $urandom_range(0, 99);
            slice = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 255);
            slot  = $urandom_range(0, NUM_SLOTS - 1);
            if (pick < (grow ? 10 : 5)) begin
               send_request(OP_ALLOC, slot, slice);
            end else if (pick < (grow ? 60 : 25)) begin
               if ($urandom_range(0, 9) < 7)
                  repeat (8)
                     if (tbl_state[slot] == ST_RUN)
                        slot = $urandom_range(0, NUM_SLOTS - 1);
               send_request(OP_SUBMIT, slot, slice);
            end else if (pick < (grow ? 80 : 50)) begin
               send_request(OP_SWITCH, slot, slice);
            end else begin
               if ($urandom_range(0, 9) < 8)
                  slot = running_slot();
               send_request(OP_SLEEP, slot, slice);
            end
         end
      end
      idle_on = 1'b1;
   endtask

   task automatic test_full_list();
      int slot;
      do
         send_request(OP_ALLOC, $urandom_range(0, NUM_SLOTS - 1), $urandom_range(0, 255));
      while (last_answer.status == STAT_OK);
      for (slot = 0; slot < NUM_SLOTS; slot++)
         send_request(OP_SUBMIT, slot,
                      $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 255));
      idle_on = 1'b0;
      repeat (20) send_request(OP_SWITCH, $urandom_range(0, NUM_SLOTS - 1), 0);
      idle_on = 1'b1;
      while (run_len > 0) begin
         idle_on = run_len % 16 < 8;
         slot = $urandom_range(0, 3) == 0 ? run_q[cur_pos] : running_slot();
         send_request(OP_SLEEP, slot, $urandom_range(0, 255));
      end
      idle_on = 1'b1;
      send_request(OP_SWITCH, 0, 0);
   endtask

   initial begin
      int i;
      for (i = 0; i < NUM_SLOTS; i++) begin
         tbl_state[i] = ST_FREE;
         tbl_slice[i] = '0;
         run_q[i]     = '0;
      end
      tbl_state[0] = ST_RUN;
      tbl_slice[0] = INIT_SLICE;
      run_len = 1;
      cur_pos = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      wait_drained();
      test_random();
      wait_drained();
      test_full_list();
      wait_drained();
      repeat (NUM_SLOTS + 10) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
